/* rtl/core/cmvg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_pkg
// Shared widths, register indexes and the sine evaluation used to build the
// quarter-wave table of the cone mesh vertex generator.
// ----------------------------------------------------------------------------
package cmvg_pkg;

	localparam int COORD_W = 16;
	localparam int CFG_W   = 16;
	localparam int COUNT_W = 9;
	localparam int IDX_W   = 8;
	localparam int TRIG_W  = 15;

	typedef enum logic [1:0] {
		CFG_BASE_RADIUS = 2'd0,
		CFG_CONE_HEIGHT = 2'd1,
		CFG_SLICE_COUNT = 2'd2,
		CFG_STACK_COUNT = 2'd3
	} cfg_idx_t;

	// Q30 odd Taylor coefficients of sin(pi/2 * u)
	localparam logic [63:0] COEF_A1 = 64'd1686629713;
	localparam logic [63:0] COEF_A3 = 64'd693598670;
	localparam logic [63:0] COEF_A5 = 64'd85569306;
	localparam logic [63:0] COEF_A7 = 64'd5027000;
	localparam logic [63:0] COEF_A9 = 64'd172272;

	// magnitude of sine for u in Q30 (0..1 of a quarter turn), rounded to Q0.15
	function automatic logic [TRIG_W-1:0] sine_mag(input logic [30:0] u_in);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] b;
		logic [63:0] s;
		u  = 64'(u_in);
		u2 = (u * u) >> 30;
		b  = COEF_A7 - ((u2 * COEF_A9) >> 30);
		b  = COEF_A5 - ((u2 * b) >> 30);
		b  = COEF_A3 - ((u2 * b) >> 30);
		b  = COEF_A1 - ((u2 * b) >> 30);
		s  = (u * b) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[TRIG_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/cmvg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_if
// Valid/ready channels for mesh cells in and vertices out.
// ----------------------------------------------------------------------------
interface cmvg_in_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [cmvg_pkg::IDX_W-1:0]   slice_index;
	logic [cmvg_pkg::IDX_W-1:0]   stack_index;

	modport source (output valid, mode, slice_index, stack_index, input ready);
	modport sink   (input valid, mode, slice_index, stack_index, output ready);
endinterface

interface cmvg_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cmvg_pkg::COORD_W-1:0] vert_x;
	logic signed [cmvg_pkg::COORD_W-1:0] vert_y;
	logic signed [cmvg_pkg::COORD_W-1:0] vert_z;
	logic                                last_vertex;

	modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
	modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface
`default_nettype wire

/* rtl/core/cmvg_cell_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_cell_pipe
// Per-cell front end: count clamping, index saturation, numerator products
// and a bit-per-stage restoring divider for angle indexes, radii and heights.
// ----------------------------------------------------------------------------
module cmvg_cell_pipe #(
	parameter int MAX_SLICES       = 256,
	parameter int MAX_STACKS       = 256,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               in_mode,
	input  wire logic [cmvg_pkg::IDX_W-1:0]         in_slice,
	input  wire logic [cmvg_pkg::IDX_W-1:0]         in_stack,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         base_radius,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         cone_height,
	input  wire logic [cmvg_pkg::COUNT_W-1:0]       slice_count,
	input  wire logic [cmvg_pkg::COUNT_W-1:0]       stack_count,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    out_mode,
	output logic [$clog2(SINE_TABLE_DEPTH)-1:0]     out_a0,
	output logic [$clog2(SINE_TABLE_DEPTH)-1:0]     out_a1,
	output logic [cmvg_pkg::CFG_W-1:0]              out_rad,
	output logic [cmvg_pkg::CFG_W-1:0]              out_r0,
	output logic [cmvg_pkg::CFG_W-1:0]              out_r1,
	output logic [cmvg_pkg::CFG_W-1:0]              out_h0,
	output logic [cmvg_pkg::CFG_W-1:0]              out_h1
);
	localparam int LOG_D  = $clog2(SINE_TABLE_DEPTH);
	localparam int SLW    = $clog2(MAX_SLICES + 1);
	localparam int STW    = $clog2(MAX_STACKS + 1);
	localparam int QW     = cmvg_pkg::CFG_W;
	localparam int NUM_A  = SLW + LOG_D;
	localparam int NUM_R  = cmvg_pkg::CFG_W + STW;
	localparam int NUM_W  = (NUM_A > NUM_R) ? NUM_A : NUM_R;
	localparam int EXT_W  = NUM_W + QW;
	localparam int NDIV   = 6;

	logic en;

	// stage 1: clamped counts and saturated indexes
	logic                       v_s1;
	logic                       mode_s1;
	logic [SLW-1:0]             sl_s1;
	logic [STW-1:0]             st_s1;
	logic [SLW-1:0]             k_s1;
	logic [STW-1:0]             j_s1;
	logic [QW-1:0]              rad_s1;
	logic [QW-1:0]              hgt_s1;

	logic [SLW-1:0] sl_c;
	logic [STW-1:0] st_c;
	logic [SLW-1:0] k_c;
	logic [STW-1:0] j_c;

	// divider chain, entry 0 is stage 2 (numerators), entry i resolves quotient bit QW-i
	logic                       v_sd    [QW+1];
	logic                       mode_sd [QW+1];
	logic [SLW-1:0]             sl_sd   [QW+1];
	logic [STW-1:0]             st_sd   [QW+1];
	logic [QW-1:0]              rad_sd  [QW+1];
	logic [NUM_W-1:0]           rem_sd  [QW+1][NDIV];
	logic [QW-1:0]              quo_sd  [QW+1][NDIV];

	assign en       = out_ready || !v_sd[QW];
	assign in_ready = en;

	always_comb begin
		if (slice_count == '0) begin
			sl_c = SLW'(1);
		end else if (32'(slice_count) > 32'(MAX_SLICES)) begin
			sl_c = SLW'(MAX_SLICES);
		end else begin
			sl_c = SLW'(slice_count);
		end
		if (stack_count == '0) begin
			st_c = STW'(1);
		end else if (32'(stack_count) > 32'(MAX_STACKS)) begin
			st_c = STW'(MAX_STACKS);
		end else begin
			st_c = STW'(stack_count);
		end
		if (32'(in_slice) > 32'(sl_c - SLW'(1))) begin
			k_c = sl_c - SLW'(1);
		end else begin
			k_c = SLW'(in_slice);
		end
		if (32'(in_stack) > 32'(st_c - STW'(1))) begin
			j_c = st_c - STW'(1);
		end else begin
			j_c = STW'(in_stack);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= in_mode;
			sl_s1   <= sl_c;
			st_s1   <= st_c;
			k_s1    <= k_c;
			j_s1    <= j_c;
			rad_s1  <= base_radius;
			hgt_s1  <= cone_height;
		end
	end

	// stage 2: dividends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sd[0] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_sd[0]   <= mode_s1;
			sl_sd[0]     <= sl_s1;
			st_sd[0]     <= st_s1;
			rad_sd[0]    <= rad_s1;
			rem_sd[0][0] <= (NUM_W'(k_s1) << LOG_D) + NUM_W'(sl_s1 >> 1);
			rem_sd[0][1] <= ((NUM_W'(k_s1) + NUM_W'(1)) << LOG_D) + NUM_W'(sl_s1 >> 1);
			rem_sd[0][2] <= NUM_W'(rad_s1) * NUM_W'(st_s1 - j_s1);
			rem_sd[0][3] <= NUM_W'(rad_s1) * NUM_W'(st_s1 - j_s1 - STW'(1));
			rem_sd[0][4] <= NUM_W'(hgt_s1) * NUM_W'(j_s1);
			rem_sd[0][5] <= NUM_W'(hgt_s1) * NUM_W'(j_s1 + STW'(1));
			for (int d = 0; d < NDIV; d++) begin
				quo_sd[0][d] <= '0;
			end
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_div
		localparam int BIT = QW - i;
		logic [NUM_W-1:0] rem_n [NDIV];
		logic [QW-1:0]    quo_n [NDIV];
		logic             qb    [NDIV];

		always_comb begin
			logic [EXT_W-1:0] trial;
			for (int d = 0; d < NDIV; d++) begin
				if (d < 2) begin
					trial = EXT_W'(sl_sd[i-1]) << BIT;
				end else begin
					trial = EXT_W'(st_sd[i-1]) << BIT;
				end
				qb[d] = EXT_W'(rem_sd[i-1][d]) >= trial;
				rem_n[d] = qb[d] ? rem_sd[i-1][d] - trial[NUM_W-1:0] : rem_sd[i-1][d];
				quo_n[d] = quo_sd[i-1][d];
				quo_n[d][BIT] = qb[d];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[i] <= 1'b0;
			end else if (en) begin
				v_sd[i] <= v_sd[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				mode_sd[i] <= mode_sd[i-1];
				sl_sd[i]   <= sl_sd[i-1];
				st_sd[i]   <= st_sd[i-1];
				rad_sd[i]  <= rad_sd[i-1];
				for (int d = 0; d < NDIV; d++) begin
					rem_sd[i][d] <= rem_n[d];
					quo_sd[i][d] <= quo_n[d];
				end
			end
		end
	end

	// angle index wraps at the table depth
	assign out_valid = v_sd[QW];
	assign out_mode  = mode_sd[QW];
	assign out_a0    = quo_sd[QW][0][LOG_D-1:0];
	assign out_a1    = quo_sd[QW][1][LOG_D-1:0];
	assign out_rad   = rad_sd[QW];
	assign out_r0    = quo_sd[QW][2];
	assign out_r1    = quo_sd[QW][3];
	assign out_h0    = quo_sd[QW][4];
	assign out_h1    = quo_sd[QW][5];

endmodule
`default_nettype wire

/* rtl/core/cmvg_vertex_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_vertex_seq
// Holds one cell and walks its vertex list, one vertex descriptor a cycle unless stalled.
// ----------------------------------------------------------------------------
module cmvg_vertex_seq #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire logic                               item_mode,
	input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] item_a0,
	input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] item_a1,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         item_rad,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         item_r0,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         item_r1,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         item_h0,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         item_h1,
	output logic                                    vd_valid,
	input  wire logic                               vd_ready,
	output logic [cmvg_pkg::CFG_W-1:0]              vd_rad,
	output logic [cmvg_pkg::CFG_W-1:0]              vd_hgt,
	output logic [$clog2(SINE_TABLE_DEPTH)-1:0]     vd_ang,
	output logic                                    vd_last
);
	localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);

	logic                       busy_q;
	logic [2:0]                 cnt_q;
	logic                       mode_q;
	logic [LOG_D-1:0]           a0_q;
	logic [LOG_D-1:0]           a1_q;
	logic [cmvg_pkg::CFG_W-1:0] rad_q;
	logic [cmvg_pkg::CFG_W-1:0] r0_q;
	logic [cmvg_pkg::CFG_W-1:0] r1_q;
	logic [cmvg_pkg::CFG_W-1:0] h0_q;
	logic [cmvg_pkg::CFG_W-1:0] h1_q;

	logic fire;

	assign vd_valid   = busy_q;
	assign vd_last    = mode_q ? (cnt_q == 3'd5) : (cnt_q == 3'd2);
	assign fire       = busy_q && vd_ready;
	assign item_ready = !busy_q || (fire && vd_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (item_valid && item_ready) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (fire) begin
			if (vd_last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			mode_q <= item_mode;
			a0_q   <= item_a0;
			a1_q   <= item_a1;
			rad_q  <= item_rad;
			r0_q   <= item_r0;
			r1_q   <= item_r1;
			h0_q   <= item_h0;
			h1_q   <= item_h1;
		end
	end

	// base wedge: origin, rim at next angle, rim at this angle
	// side quad: two triangles over rings j and j+1
	always_comb begin
		vd_rad = r0_q;
		vd_hgt = h0_q;
		vd_ang = a0_q;
		if (!mode_q) begin
			case (cnt_q)
				3'd0: begin
					vd_rad = '0;
					vd_hgt = '0;
					vd_ang = '0;
				end
				3'd1: begin
					vd_rad = rad_q;
					vd_hgt = '0;
					vd_ang = a1_q;
				end
				default: begin
					vd_rad = rad_q;
					vd_hgt = '0;
					vd_ang = a0_q;
				end
			endcase
		end else begin
			case (cnt_q)
				3'd0: begin
					vd_rad = r0_q;
					vd_hgt = h0_q;
					vd_ang = a1_q;
				end
				3'd1, 3'd3: begin
					vd_rad = r1_q;
					vd_hgt = h1_q;
					vd_ang = a1_q;
				end
				3'd4: begin
					vd_rad = r1_q;
					vd_hgt = h1_q;
					vd_ang = a0_q;
				end
				default: begin
					vd_rad = r0_q;
					vd_hgt = h0_q;
					vd_ang = a0_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/core/cmvg_vertex_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmvg_vertex_pipe
// Quarter-wave sine lookup, radius scaling and coordinate saturation,
// one vertex per cycle unless the output stalls, over three register stages.
// ----------------------------------------------------------------------------
module cmvg_vertex_pipe #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         in_rad,
	input  wire logic [cmvg_pkg::CFG_W-1:0]         in_hgt,
	input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0] in_ang,
	input  wire logic                               in_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [cmvg_pkg::COORD_W-1:0]     out_x,
	output logic signed [cmvg_pkg::COORD_W-1:0]     out_y,
	output logic signed [cmvg_pkg::COORD_W-1:0]     out_z,
	output logic                                    out_last
);
	localparam int LOG_D  = $clog2(SINE_TABLE_DEPTH);
	localparam int QD     = SINE_TABLE_DEPTH / 4;
	localparam int IW     = LOG_D - 1;
	localparam int TW     = cmvg_pkg::TRIG_W;
	localparam int RW     = cmvg_pkg::CFG_W;
	localparam int PW     = RW + TW;
	localparam int CW     = cmvg_pkg::COORD_W;

	typedef logic [TW-1:0] rom_t [QD+1];

	function automatic rom_t build_rom();
		rom_t r;
		for (int m = 0; m <= QD; m++) begin
			r[m] = cmvg_pkg::sine_mag(31'(m) << (32 - LOG_D));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	function automatic logic [CW-1:0] sat_coord(input logic [PW-1:0] prod, input logic neg);
		logic [PW:0] m;
		m = ({1'b0, prod} + (PW+1)'(16384)) >> 15;
		if (neg) begin
			if (m > (PW+1)'(32768)) begin
				return {1'b1, {(CW-1){1'b0}}};
			end
			return CW'(-m);
		end
		if (m > (PW+1)'(32767)) begin
			return {1'b0, {(CW-1){1'b1}}};
		end
		return CW'(m);
	endfunction

	logic en;

	logic [LOG_D-1:0] cang;
	logic [IW-1:0]    sadr;
	logic [IW-1:0]    cadr;

	logic           v_s1;
	logic [TW-1:0]  smag_s1;
	logic [TW-1:0]  cmag_s1;
	logic           sneg_s1;
	logic           cneg_s1;
	logic [RW-1:0]  rad_s1;
	logic [RW-1:0]  hgt_s1;
	logic           last_s1;

	logic           v_s2;
	logic [PW-1:0]  px_s2;
	logic [PW-1:0]  pz_s2;
	logic           sneg_s2;
	logic           cneg_s2;
	logic [RW-1:0]  hgt_s2;
	logic           last_s2;

	logic           v_s3;
	logic [CW-1:0]  x_s3;
	logic [CW-1:0]  y_s3;
	logic [CW-1:0]  z_s3;
	logic           last_s3;

	assign en       = out_ready || !v_s3;
	assign in_ready = en;

	// cosine is the sine a quarter turn later; odd quadrants mirror the index
	always_comb begin
		cang = in_ang + LOG_D'(QD);
		if (in_ang[LOG_D-2]) begin
			sadr = IW'(QD) - IW'(in_ang[LOG_D-3:0]);
		end else begin
			sadr = IW'(in_ang[LOG_D-3:0]);
		end
		if (cang[LOG_D-2]) begin
			cadr = IW'(QD) - IW'(cang[LOG_D-3:0]);
		end else begin
			cadr = IW'(cang[LOG_D-3:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smag_s1 <= SINE_ROM[sadr];
			cmag_s1 <= SINE_ROM[cadr];
			sneg_s1 <= in_ang[LOG_D-1];
			cneg_s1 <= cang[LOG_D-1];
			rad_s1  <= in_rad;
			hgt_s1  <= in_hgt;
			last_s1 <= in_last;

			px_s2   <= PW'(rad_s1) * PW'(smag_s1);
			pz_s2   <= PW'(rad_s1) * PW'(cmag_s1);
			sneg_s2 <= sneg_s1;
			cneg_s2 <= cneg_s1;
			hgt_s2  <= hgt_s1;
			last_s2 <= last_s1;

			x_s3    <= sat_coord(px_s2, sneg_s2);
			z_s3    <= sat_coord(pz_s2, cneg_s2);
			y_s3    <= hgt_s2[RW-1] ? {1'b0, {(CW-1){1'b1}}} : CW'(hgt_s2);
			last_s3 <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_x     = x_s3;
	assign out_y     = y_s3;
	assign out_z     = z_s3;
	assign out_last  = last_s3;

endmodule
`default_nettype wire

/* rtl/core/cone_mesh_vertex_generator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cone_mesh_vertex_generator_unit
// Cone tessellation: turns mesh cells into base wedge or side quad vertices.
// ----------------------------------------------------------------------------
// A cell is taken in every unstalled cycle into an 18-stage front pipeline
// (clamping, numerator products, then one quotient bit per stage for angle
// indexes, ring radii and ring heights). A sequencer then walks the cell's
// vertex list and hands one vertex per unstalled cycle to a three-stage sine
// lookup and scaling pipeline, so a side quad occupies the output for six
// vertices and a base wedge for three; the vertex sequencer sets the
// sustained rate. The user must write registers through the plain write port
// only while no cell is in flight; the block itself does not enforce this.
module cone_mesh_vertex_generator_unit #(
	parameter int MAX_SLICES       = 256,
	parameter int MAX_STACKS       = 256,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [cmvg_pkg::CFG_W-1:0]   cfg_wdata,
	cmvg_in_if.sink                           in_ch,
	cmvg_out_if.source                        out_ch
);
	localparam int LOG_D = $clog2(SINE_TABLE_DEPTH);
	localparam int RW    = cmvg_pkg::CFG_W;

	logic [RW-1:0]                    base_radius_q;
	logic [RW-1:0]                    cone_height_q;
	logic [cmvg_pkg::COUNT_W-1:0]     slice_count_q;
	logic [cmvg_pkg::COUNT_W-1:0]     stack_count_q;

	logic             cp_valid;
	logic             cp_ready;
	logic             cp_mode;
	logic [LOG_D-1:0] cp_a0;
	logic [LOG_D-1:0] cp_a1;
	logic [RW-1:0]    cp_rad;
	logic [RW-1:0]    cp_r0;
	logic [RW-1:0]    cp_r1;
	logic [RW-1:0]    cp_h0;
	logic [RW-1:0]    cp_h1;

	logic             vd_valid;
	logic             vd_ready;
	logic [RW-1:0]    vd_rad;
	logic [RW-1:0]    vd_hgt;
	logic [LOG_D-1:0] vd_ang;
	logic             vd_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_radius_q <= RW'(256);
			cone_height_q <= RW'(256);
			slice_count_q <= cmvg_pkg::COUNT_W'(16);
			stack_count_q <= cmvg_pkg::COUNT_W'(8);
		end else if (cfg_we) begin
			case (cmvg_pkg::cfg_idx_t'(cfg_index))
				cmvg_pkg::CFG_BASE_RADIUS: base_radius_q <= cfg_wdata;
				cmvg_pkg::CFG_CONE_HEIGHT: cone_height_q <= cfg_wdata;
				cmvg_pkg::CFG_SLICE_COUNT: slice_count_q <= cfg_wdata[cmvg_pkg::COUNT_W-1:0];
				cmvg_pkg::CFG_STACK_COUNT: stack_count_q <= cfg_wdata[cmvg_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	cmvg_cell_pipe #(
		.MAX_SLICES       (MAX_SLICES),
		.MAX_STACKS       (MAX_STACKS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_cell (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.in_ready    (in_ch.ready),
		.in_mode     (in_ch.mode),
		.in_slice    (in_ch.slice_index),
		.in_stack    (in_ch.stack_index),
		.base_radius (base_radius_q),
		.cone_height (cone_height_q),
		.slice_count (slice_count_q),
		.stack_count (stack_count_q),
		.out_valid   (cp_valid),
		.out_ready   (cp_ready),
		.out_mode    (cp_mode),
		.out_a0      (cp_a0),
		.out_a1      (cp_a1),
		.out_rad     (cp_rad),
		.out_r0      (cp_r0),
		.out_r1      (cp_r1),
		.out_h0      (cp_h0),
		.out_h1      (cp_h1)
	);

	cmvg_vertex_seq #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (cp_valid),
		.item_ready (cp_ready),
		.item_mode  (cp_mode),
		.item_a0    (cp_a0),
		.item_a1    (cp_a1),
		.item_rad   (cp_rad),
		.item_r0    (cp_r0),
		.item_r1    (cp_r1),
		.item_h0    (cp_h0),
		.item_h1    (cp_h1),
		.vd_valid   (vd_valid),
		.vd_ready   (vd_ready),
		.vd_rad     (vd_rad),
		.vd_hgt     (vd_hgt),
		.vd_ang     (vd_ang),
		.vd_last    (vd_last)
	);

	cmvg_vertex_pipe #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_vtx (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vd_valid),
		.in_ready  (vd_ready),
		.in_rad    (vd_rad),
		.in_hgt    (vd_hgt),
		.in_ang    (vd_ang),
		.in_last   (vd_last),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_x     (out_ch.vert_x),
		.out_y     (out_ch.vert_y),
		.out_z     (out_ch.vert_z),
		.out_last  (out_ch.last_vertex)
	);

endmodule
`default_nettype wire
